>>> rtl/core/aci_pkg.sv
// Package for the animation clock interpolator.
// Item types, table row type, register indexes and reset values.
// No dependencies.
package aci_pkg;

  typedef struct packed {
    logic              kind;
    logic [31:0]       object_id;
    logic signed [31:0] live_frame;
    logic signed [31:0] anim_speed;
    logic [31:0]       now_us;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] frame_out;
    logic              interpolated;
    logic              table_full;
  } out_item_t;

  typedef struct packed {
    logic [31:0]       key;
    logic signed [31:0] prev;
    logic signed [31:0] curr;
    logic [31:0]       changed_at;
    logic [31:0]       seen_step;
  } row_t;

  localparam logic [7:0] REG_INTERP_ENABLE = 8'd0;
  localparam logic [7:0] REG_TICK_PERIOD   = 8'd1;
  localparam logic [7:0] REG_FAST_CHANGE   = 8'd2;
  localparam logic [7:0] REG_STALE_FRAMES  = 8'd3;

  localparam logic        RST_INTERP_ENABLE = 1'b1;
  localparam logic [19:0] RST_TICK_PERIOD   = 20'd33333;
  localparam logic [19:0] RST_FAST_CHANGE   = 20'd16667;
  localparam logic [7:0]  RST_STALE_FRAMES  = 8'd4;

  localparam int DIV_BITS = 53;

endpackage

>>> rtl/core/anim_clock_interpolator.sv
// Animation clock interpolator: per-object frame table with smoothing.
// Uses aci_pkg for item types, row type and register codes.
//
// Usage: in_valid/in_stall carries items of two kinds. A draw item (kind 0)
// yields one result on out_valid/out_stall; a game-step item (kind 1) yields
// none and ages the table. cfg_valid/cfg_ready writes registers (always ready);
// write them only while the block is idle.
// Flow: one item at a time. The table is one memory of TABLE_ENTRIES rows,
// read one row a cycle by a lookup or aging sweep. A draw that interpolates
// then runs a multiply and the 53-step restoring divider. A pass-through
// draw skips those; a disabled draw also skips the lookup.
// Reset empties the table (valid bits cleared at once), zeroes the step count
// and loads register defaults; no clearing pass. A result waits in the output
// register while out_stall is high; the next item is still accepted, and its
// result is held back until the output register frees.
module anim_clock_interpolator #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  aci_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output aci_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [AW:0] LAST_IDX = (AW + 1)'(TABLE_ENTRIES);
  localparam logic [5:0] DIV_LAST = 6'(aci_pkg::DIV_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH, S_AGE, S_UPD, S_MUL, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t             state_r;
  aci_pkg::in_item_t  item_r;
  aci_pkg::row_t      mem [TABLE_ENTRIES];
  aci_pkg::row_t      rdata_r;
  aci_pkg::row_t      row_r;
  aci_pkg::row_t      wr_row;
  aci_pkg::out_item_t res_r;
  aci_pkg::out_item_t out_data_r;
  logic                     out_valid_r;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [31:0]              step_r;
  logic                     en_r;
  logic [19:0]              tick_cfg_r;
  logic [19:0]              fast_r;
  logic [7:0]               stale_r;
  logic [AW:0]              idx_r;
  logic                     chk_vld_r;
  logic [AW-1:0]            chk_idx_r;
  logic                     hit_r;
  logic                     free_vld_r;
  logic [AW-1:0]            free_idx_r;
  logic [AW-1:0]            slot_r;
  logic signed [31:0]       new_prev_r;
  logic                     neg_r;
  logic [32:0]              mag_r;
  logic [19:0]              held_r;
  logic [52:0]              prod_r;
  logic [19:0]              rem_r;
  logic [5:0]               div_cnt_r;

  logic [19:0] tick;
  logic        vld_c;
  logic        match;
  logic        sweep_done;
  logic        changed;
  logic [32:0] delta;
  logic [32:0] absd;
  logic [31:0] abss;
  logic [33:0] two_d;
  logic [33:0] three_s;
  logic [31:0] since;
  logic        snap;
  logic signed [31:0] np;
  logic signed [31:0] nc;
  logic [31:0] nchg;
  logic [31:0] held;
  logic        stop;
  logic [32:0] diff;
  logic [20:0] rem2;
  logic [20:0] rem_sub;
  logic        ge;
  logic [32:0] sq;
  logic [31:0] age;

  assign tick       = (tick_cfg_r == 20'd0) ? 20'd1 : tick_cfg_r;
  assign vld_c      = valid_r[chk_idx_r];
  assign match      = chk_vld_r && vld_c && (rdata_r.key == item_r.object_id);
  assign sweep_done = !chk_vld_r && (idx_r == LAST_IDX);
  assign age        = step_r - rdata_r.seen_step;

  always_comb begin
    changed = row_r.curr != item_r.live_frame;
    delta   = {item_r.live_frame[31], item_r.live_frame} - {row_r.curr[31], row_r.curr};
    absd    = delta[32] ? (33'd0 - delta) : delta;
    abss    = item_r.anim_speed[31] ? (32'd0 - item_r.anim_speed) : item_r.anim_speed;
    two_d   = {absd, 1'b0};
    three_s = {2'b00, abss} + {1'b0, abss, 1'b0};
    since   = item_r.now_us - row_r.changed_at;
    snap    = (since < {12'd0, fast_r}) || (item_r.anim_speed == 32'sd0) ||
              (delta[32] && !item_r.anim_speed[31]) ||
              (!delta[32] && (delta != 33'd0) && item_r.anim_speed[31]) ||
              (two_d > three_s);
    nc      = item_r.live_frame;
    if (!hit_r) begin
      np   = item_r.live_frame;
      nchg = item_r.now_us;
    end else if (changed) begin
      np   = snap ? item_r.live_frame : row_r.curr;
      nchg = item_r.now_us;
    end else begin
      np   = row_r.prev;
      nchg = row_r.changed_at;
    end
    held = item_r.now_us - nchg;
    stop = (np == nc) || (held >= {12'd0, tick});
    diff = {nc[31], nc} - {np[31], np};
    wr_row.key        = item_r.object_id;
    wr_row.prev       = stop ? nc : np;
    wr_row.curr       = nc;
    wr_row.changed_at = nchg;
    wr_row.seen_step  = step_r;
    rem2    = {rem_r, prod_r[52]};
    rem_sub = rem2 - {1'b0, tick};
    ge      = rem2 >= {1'b0, tick};
    sq      = neg_r ? (33'd0 - prod_r[32:0]) : prod_r[32:0];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_UPD) begin
      mem[slot_r] <= wr_row;
    end
    rdata_r <= mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      step_r      <= 32'd0;
      en_r        <= aci_pkg::RST_INTERP_ENABLE;
      tick_cfg_r  <= aci_pkg::RST_TICK_PERIOD;
      fast_r      <= aci_pkg::RST_FAST_CHANGE;
      stale_r     <= aci_pkg::RST_STALE_FRAMES;
      chk_vld_r   <= 1'b0;
      idx_r       <= '0;
      free_vld_r  <= 1'b0;
      hit_r       <= 1'b0;
      div_cnt_r   <= 6'd0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          aci_pkg::REG_INTERP_ENABLE: en_r       <= cfg_data[0];
          aci_pkg::REG_TICK_PERIOD:   tick_cfg_r <= cfg_data[19:0];
          aci_pkg::REG_FAST_CHANGE:   fast_r     <= cfg_data[19:0];
          aci_pkg::REG_STALE_FRAMES:  stale_r    <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          idx_r      <= '0;
          chk_vld_r  <= 1'b0;
          free_vld_r <= 1'b0;
          if (in_valid) begin
            item_r <= in_data;
            if (in_data.kind) begin
              step_r  <= step_r + 32'd1;
              state_r <= S_AGE;
            end else if (!en_r) begin
              res_r   <= '{frame_out: in_data.live_frame, interpolated: 1'b0,
                           table_full: 1'b0};
              state_r <= S_OUT;
            end else begin
              state_r <= S_SRCH;
            end
          end
        end
        S_SRCH: begin
          if (match) begin
            hit_r   <= 1'b1;
            slot_r  <= chk_idx_r;
            row_r   <= rdata_r;
            state_r <= S_UPD;
          end else if (sweep_done) begin
            if (free_vld_r) begin
              hit_r   <= 1'b0;
              slot_r  <= free_idx_r;
              state_r <= S_UPD;
            end else begin
              res_r   <= '{frame_out: item_r.live_frame, interpolated: 1'b0,
                           table_full: 1'b1};
              state_r <= S_OUT;
            end
          end else begin
            if (chk_vld_r && !vld_c && !free_vld_r) begin
              free_vld_r <= 1'b1;
              free_idx_r <= chk_idx_r;
            end
            chk_vld_r <= idx_r != LAST_IDX;
            chk_idx_r <= idx_r[AW-1:0];
            if (idx_r != LAST_IDX) begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        S_AGE: begin
          if (chk_vld_r && vld_c && (age > {24'd0, stale_r})) begin
            valid_r[chk_idx_r] <= 1'b0;
          end
          if (sweep_done) begin
            state_r <= S_IDLE;
          end else begin
            chk_vld_r <= idx_r != LAST_IDX;
            chk_idx_r <= idx_r[AW-1:0];
            if (idx_r != LAST_IDX) begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        S_UPD: begin
          valid_r[slot_r] <= 1'b1;
          if (stop) begin
            res_r   <= '{frame_out: item_r.live_frame, interpolated: 1'b0,
                         table_full: 1'b0};
            state_r <= S_OUT;
          end else begin
            new_prev_r <= np;
            neg_r      <= diff[32];
            mag_r      <= diff[32] ? (33'd0 - diff) : diff;
            held_r     <= held[19:0];
            state_r    <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r    <= {20'd0, mag_r} * {33'd0, held_r};
          rem_r     <= 20'd0;
          div_cnt_r <= 6'd0;
          state_r   <= S_DIV;
        end
        S_DIV: begin
          rem_r     <= ge ? rem_sub[19:0] : rem2[19:0];
          prod_r    <= {prod_r[51:0], ge};
          div_cnt_r <= div_cnt_r + 6'd1;
          if (div_cnt_r == DIV_LAST) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          res_r   <= '{frame_out: new_prev_r + $signed(sq[31:0]), interpolated: 1'b1,
                       table_full: 1'b0};
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD |=> valid_r[$past(slot_r)])
    else $error("updated entry not marked valid");
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < tick)
    else $error("divider remainder out of range");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> div_cnt_r <= DIV_LAST)
    else $error("divider count overrun");
  a_full_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.table_full |-> !out_data_r.interpolated)
    else $error("table full item flagged interpolated");
`endif

endmodule

>>> sim/tb_anim_clock_interpolator.sv
// Testbench for anim_clock_interpolator: directed and random draw and game-step items
// are checked against a predictor of the object table. Depends on rtl/core/aci_pkg.sv.
`timescale 1ns / 100ps

module tb_anim_clock_interpolator;

  localparam int  ENTRIES     = 64;
  localparam int  CYCLE_LIMIT = 2000000;
  localparam int  SETTLE      = 160;
  localparam logic KIND_DRAW  = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  aci_pkg::in_item_t in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  aci_pkg::out_item_t out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  anim_clock_interpolator #(.TABLE_ENTRIES(ENTRIES)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic        pr_enable;
  logic [19:0] pr_tick;
  logic [19:0] pr_fast;
  logic [7:0]  pr_stale;
  logic        tbl_valid [ENTRIES];
  logic [31:0] tbl_key [ENTRIES];
  longint      tbl_prev [ENTRIES];
  longint      tbl_curr [ENTRIES];
  logic [31:0] tbl_changed [ENTRIES];
  logic [31:0] tbl_seen [ENTRIES];
  logic [31:0] game_steps;

  aci_pkg::out_item_t expected_frames[$];
  int          errors = 0;
  int          frames_checked = 0;
  int          items_sent = 0;
  int          interp_seen = 0;
  int          full_seen = 0;
  int          cycles = 0;
  int          burst_left = 0;
  logic [15:0] stall_phase = '0;
  logic [31:0] clock_us;

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $realtime, cycles);
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    case (stall_phase[11:10])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= (stall_phase[6:4] == 3'd0);
      default: out_stall <= ($urandom_range(0, 1) == 1);
    endcase
  end

  always @(posedge clk) begin
    aci_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        errors++;
        $display("%0t unexpected result: frame %h interp %b full %b", $realtime,
                 out_data.frame_out, out_data.interpolated, out_data.table_full);
      end else begin
        want = expected_frames.pop_front();
        frames_checked++;
        if (want.interpolated) interp_seen++;
        if (want.table_full) full_seen++;
        if (out_data.frame_out !== want.frame_out) begin
          errors++;
          $display("%0t frame_out expected %h actual %h", $realtime,
                   want.frame_out, out_data.frame_out);
        end
        if (out_data.interpolated !== want.interpolated) begin
          errors++;
          $display("%0t interpolated expected %b actual %b", $realtime,
                   want.interpolated, out_data.interpolated);
        end
        if (out_data.table_full !== want.table_full) begin
          errors++;
          $display("%0t table_full expected %b actual %b", $realtime,
                   want.table_full, out_data.table_full);
        end
      end
    end
  end

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic predict_frame(input aci_pkg::in_item_t it);
    aci_pkg::out_item_t r;
    longint    live, speed, delta, res;
    int        slot, free_slot;
    logic      snap;
    logic [31:0] since, held, tick;
    live = longint'($signed(it.live_frame));
    speed = longint'($signed(it.anim_speed));
    slot = -1;
    free_slot = -1;
    if (it.kind == KIND_STEP) begin
      game_steps = game_steps + 1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (tbl_valid[i] && (game_steps - tbl_seen[i]) > {24'd0, pr_stale}) tbl_valid[i] = 1'b0;
      end
      return;
    end
    r.frame_out = it.live_frame;
    r.interpolated = 1'b0;
    r.table_full = 1'b0;
    if (!pr_enable) begin
      expected_frames.push_back(r);
      return;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_valid[i]) begin
        if (slot < 0 && tbl_key[i] == it.object_id) slot = i;
      end else if (free_slot < 0 && slot < 0) begin
        free_slot = i;
      end
    end
    if (slot < 0) begin
      if (free_slot < 0) begin
        r.table_full = 1'b1;
        expected_frames.push_back(r);
        return;
      end
      slot = free_slot;
      tbl_valid[slot] = 1'b1;
      tbl_key[slot] = it.object_id;
      tbl_prev[slot] = live;
      tbl_curr[slot] = live;
      tbl_changed[slot] = it.now_us;
    end else if (tbl_curr[slot] != live) begin
      since = it.now_us - tbl_changed[slot];
      delta = live - tbl_curr[slot];
      snap = (since < {12'd0, pr_fast}) || (speed == 0) ||
             (delta < 0 && speed > 0) || (delta > 0 && speed < 0) ||
             (magnitude(delta) * 2 > magnitude(speed) * 3);
      tbl_prev[slot] = snap ? live : tbl_curr[slot];
      tbl_curr[slot] = live;
      tbl_changed[slot] = it.now_us;
    end
    tbl_seen[slot] = game_steps;
    tick = (pr_tick == 0) ? 32'd1 : {12'd0, pr_tick};
    held = it.now_us - tbl_changed[slot];
    if (tbl_prev[slot] == tbl_curr[slot] || held >= tick) begin
      tbl_prev[slot] = tbl_curr[slot];
    end else begin
      res = tbl_prev[slot] +
            ((tbl_curr[slot] - tbl_prev[slot]) * longint'(held)) / longint'(tick);
      r.frame_out = res[31:0];
      r.interpolated = 1'b1;
    end
    expected_frames.push_back(r);
  endtask

  task automatic send_item(input aci_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_frame(it);
    items_sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 15);
    end else begin
      burst_left--;
    end
  endtask

  task automatic draw(input logic [31:0] id, input logic [31:0] live,
                      input logic [31:0] speed, input logic [31:0] now);
    aci_pkg::in_item_t it;
    it.kind = KIND_DRAW;
    it.object_id = id;
    it.live_frame = live;
    it.anim_speed = speed;
    it.now_us = now;
    send_item(it);
  endtask

  task automatic game_step();
    aci_pkg::in_item_t it;
    it = '0;
    it.kind = KIND_STEP;
    it.object_id = $urandom;
    it.live_frame = $urandom;
    it.anim_speed = $urandom;
    it.now_us = $urandom;
    send_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      aci_pkg::REG_INTERP_ENABLE: pr_enable = value[0];
      aci_pkg::REG_TICK_PERIOD:   pr_tick = value[19:0];
      aci_pkg::REG_FAST_CHANGE:   pr_fast = value[19:0];
      aci_pkg::REG_STALE_FRAMES:  pr_stale = value[7:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic en, input logic [19:0] tick,
                           input logic [19:0] fast, input logic [7:0] stale);
    drain();
    write_reg(aci_pkg::REG_INTERP_ENABLE, {31'd0, en});
    write_reg(aci_pkg::REG_TICK_PERIOD, {12'd0, tick});
    write_reg(aci_pkg::REG_FAST_CHANGE, {12'd0, fast});
    write_reg(aci_pkg::REG_STALE_FRAMES, {24'd0, stale});
  endtask

  task automatic test_directed();
    logic [31:0] t;
    t = 32'd1000000;
    draw(32'hA, 32'h10000, 32'h10000, t);
    draw(32'hA, 32'h20000, 32'h10000, t + 20000);
    draw(32'hA, 32'h20000, 32'h10000, t + 30000);
    draw(32'hA, 32'h20000, 32'h10000, t + 60000);
    draw(32'hA, 32'h30000, 32'h10000, t + 80000);
    draw(32'hA, 32'h40000, 32'h10000, t + 85000);
    draw(32'hA, 32'h50000, 32'h0, t + 120000);
    draw(32'hA, 32'h40000, 32'h10000, t + 150000);
    draw(32'hA, 32'h70000, 32'h10000, t + 180000);
    draw(32'hA, 32'h88000, 32'h18000, t + 200000);
    draw(32'hA, 32'h88000, 32'h18000, t + 199990);
    draw(32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFF0);
    draw(32'hFFFFFFFF, 32'h7FFF0000, 32'h80000000, 32'h00000010);
    draw(32'hFFFFFFFF, 32'h7FFF0000, 32'h80000000, 32'h00000020);
    draw(32'h0, 32'h80000000, 32'h7FFFFFFF, t);
    draw(32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF, t + 20000);
    draw(32'h0, 32'h80000000, 32'hFFFF0000, t + 40000);
    draw(32'h0, 32'h80000000, 32'hFFFF0000, t + 50000);
    game_step();
    game_step();
    draw(32'hA, 32'h88000, 32'h18000, t + 210000);
  endtask

  task automatic test_table_full();
    configure(1'b1, 20'd33333, 20'd16667, 8'd255);
    for (int i = 0; i < ENTRIES + 3; i++)
      draw(32'h1000 + i, $urandom, $urandom, $urandom);
    draw(32'h1000, 32'h5, 32'h1, 32'h0);
  endtask

  task automatic test_prune();
    configure(1'b1, 20'd33333, 20'd16667, 8'd0);
    game_step();
    game_step();
    draw(32'h2000, 32'h100, 32'h100, 32'd5000);
    draw(32'h2001, 32'h100, 32'h100, 32'd5000);
    game_step();
    draw(32'h2000, 32'h300, 32'h200, 32'd40000);
    draw(32'h2000, 32'h300, 32'h200, 32'd45000);
  endtask

  task automatic test_disabled();
    configure(1'b0, 20'd33333, 20'd16667, 8'd4);
    for (int i = 0; i < 6; i++) draw(32'h2000 + i % 2, $urandom, $urandom, $urandom);
    game_step();
    configure(1'b1, 20'd0, 20'd0, 8'd4);
    draw(32'h3000, 32'h10, 32'h10, 32'd100);
    draw(32'h3000, 32'h20, 32'h10, 32'd100);
  endtask

  task automatic random_traffic(input int count, input int id_pool, input int max_step);
    logic [31:0] live [16];
    logic [31:0] speed [16];
    aci_pkg::in_item_t it;
    int          k, roll;
    for (int i = 0; i < 16; i++) begin
      live[i] = $urandom;
      speed[i] = $urandom_range(1, 32'h40000);
    end
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (n == count / 2) drain();
      if (roll < 5) begin
        game_step();
      end else if (roll < 13) begin
        it.kind = KIND_DRAW;
        it.object_id = $urandom;
        it.live_frame = $urandom;
        it.anim_speed = $urandom;
        it.now_us = $urandom;
        send_item(it);
      end else begin
        k = $urandom_range(0, id_pool - 1);
        clock_us = clock_us + $urandom_range(0, max_step);
        case ($urandom_range(0, 9))
          0: speed[k] = 32'd0;
          1: speed[k] = -speed[k];
          2: speed[k] = $urandom;
          default: ;
        endcase
        if ($urandom_range(0, 2) != 0)
          live[k] = live[k] + $signed(speed[k]) * $urandom_range(1, 8) / 4;
        draw(32'hC0DE0000 + k, live[k], speed[k], clock_us);
      end
    end
  endtask

  initial begin
    pr_enable = aci_pkg::RST_INTERP_ENABLE;
    pr_tick = aci_pkg::RST_TICK_PERIOD;
    pr_fast = aci_pkg::RST_FAST_CHANGE;
    pr_stale = aci_pkg::RST_STALE_FRAMES;
    game_steps = '0;
    clock_us = $urandom;
    for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_table_full();
    test_prune();
    test_disabled();
    configure(1'b1, 20'd33333, 20'd16667, 8'd4);
    random_traffic(300, 12, 12000);
    configure(1'b1, 20'd1000, 20'd0, 8'd255);
    random_traffic(200, 16, 400);
    configure(1'b1, 20'd1000000, 20'd1000000, 8'd0);
    random_traffic(200, 8, 300000);
    configure(1'b1, 20'd1, 20'd1000000, 8'd2);
    random_traffic(100, 8, 4);
    configure(1'b1, 20'd50000, 20'd5000, 8'd8);
    random_traffic(250, 16, 20000);

    drain();
    if (expected_frames.size() != 0) errors++;
    $display("Sent %0d items, checked %0d results (%0d interpolated, %0d table full)",
             items_sent, frames_checked, interp_seen, full_seen);
    $display("Covered register extremes, pruning, disabled mode and time wrap; %0d errors",
             errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
